FILE: src/bfsssp_pkg.sv
`default_nettype none
package bfsssp_pkg;

    localparam int MAX_V      = 1024;
    localparam int V_BITS     = 10;
    localparam int N_BITS     = 11;
    localparam int MAX_E      = 4096;
    localparam int E_BITS     = 12;
    localparam int SLOT_BITS  = 13;
    localparam int DIST_BITS  = 48;
    localparam int PRED_BITS  = 11;
    localparam int W_BITS     = 32;
    localparam int ROUND_BITS = 10;
    localparam int TRAV_BITS  = 23;

    localparam logic [TRAV_BITS-1:0] TRAV_CAP = 23'd4194304;
    localparam logic [N_BITS-1:0]    N_MAX    = 11'd1024;
    localparam logic [SLOT_BITS-1:0] E_LIMIT  = 13'd4096;

    localparam logic signed [DIST_BITS-1:0] DIST_INF = {1'b0, {(DIST_BITS-1){1'b1}}};
    localparam logic signed [DIST_BITS:0]   SUM_HI   = {2'b00, {(DIST_BITS-2){1'b1}}, 1'b0};
    localparam logic signed [DIST_BITS:0]   SUM_LO   = {2'b11, {(DIST_BITS-1){1'b0}}};

    localparam logic [1:0] OP_CLEAR = 2'd0;
    localparam logic [1:0] OP_LOAD  = 2'd1;
    localparam logic [1:0] OP_RUN   = 2'd2;
    localparam logic [1:0] OP_QUERY = 2'd3;

    localparam logic [1:0] KIND_RUN    = 2'd0;
    localparam logic [1:0] KIND_QUERY  = 2'd1;
    localparam logic [1:0] KIND_REJECT = 2'd2;

    typedef logic [4:0] t_cmd;
    localparam t_cmd CMD_NOP     = 5'd0;
    localparam t_cmd CMD_CAPTURE = 5'd1;
    localparam t_cmd CMD_CLR     = 5'd2;
    localparam t_cmd CMD_LD_RD   = 5'd3;
    localparam t_cmd CMD_LD_WR   = 5'd4;
    localparam t_cmd CMD_Q_RD    = 5'd5;
    localparam t_cmd CMD_INIT    = 5'd6;
    localparam t_cmd CMD_SRC     = 5'd7;
    localparam t_cmd CMD_RSTART  = 5'd8;
    localparam t_cmd CMD_V_RD    = 5'd9;
    localparam t_cmd CMD_V_NEXT  = 5'd10;
    localparam t_cmd CMD_V_SKIP  = 5'd11;
    localparam t_cmd CMD_V_TAKE  = 5'd12;
    localparam t_cmd CMD_E_RD    = 5'd13;
    localparam t_cmd CMD_E_NEXT  = 5'd14;
    localparam t_cmd CMD_E_TO    = 5'd15;
    localparam t_cmd CMD_E_UPD   = 5'd16;
    localparam t_cmd CMD_EMIT    = 5'd17;

    typedef struct packed {
        logic [1:0] op;
        logic       out_free;
        logic       ld_reject;
        logic       sweep_last;
        logic       round_go;
        logic       vdone;
        logic       v_act;
        logic       v_inf;
        logic       e_done;
        logic       e_stale;
    } t_status;

endpackage
`default_nettype wire

FILE: src/bfsssp_ram.sv
`default_nettype none
module bfsssp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end
endmodule
`default_nettype wire

FILE: src/bfsssp_ctrl.sv
`default_nettype none
module bfsssp_ctrl (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_in_valid,
    output logic                      o_in_ready,
    input  wire bfsssp_pkg::t_status  i_status,
    output bfsssp_pkg::t_cmd          o_cmd
);
    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_CLR    = 4'd1;
    localparam logic [3:0] S_DISP   = 4'd2;
    localparam logic [3:0] S_LD_RD  = 4'd3;
    localparam logic [3:0] S_LD_WR  = 4'd4;
    localparam logic [3:0] S_Q_RD   = 4'd5;
    localparam logic [3:0] S_INIT   = 4'd6;
    localparam logic [3:0] S_SRC    = 4'd7;
    localparam logic [3:0] S_ROUND  = 4'd8;
    localparam logic [3:0] S_V_RD   = 4'd9;
    localparam logic [3:0] S_V_CHK  = 4'd10;
    localparam logic [3:0] S_E_RD   = 4'd11;
    localparam logic [3:0] S_E_TO   = 4'd12;
    localparam logic [3:0] S_E_UPD  = 4'd13;
    localparam logic [3:0] S_RESP   = 4'd14;

    logic [3:0] r_state;
    logic [3:0] n_state;

    assign o_in_ready = (r_state == S_IDLE);

    always_comb begin
        n_state = r_state;
        o_cmd   = bfsssp_pkg::CMD_NOP;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd   = bfsssp_pkg::CMD_CAPTURE;
                    n_state = S_DISP;
                end
            end
            S_CLR: begin
                o_cmd = bfsssp_pkg::CMD_CLR;
                if (i_status.sweep_last) n_state = S_IDLE;
            end
            S_DISP: begin
                unique case (i_status.op)
                    bfsssp_pkg::OP_CLEAR: n_state = S_CLR;
                    bfsssp_pkg::OP_LOAD:  n_state = S_LD_RD;
                    bfsssp_pkg::OP_RUN:   n_state = S_INIT;
                    default:              n_state = S_Q_RD;
                endcase
            end
            S_LD_RD: begin
                if (i_status.ld_reject) begin
                    n_state = S_RESP;
                end else begin
                    o_cmd   = bfsssp_pkg::CMD_LD_RD;
                    n_state = S_LD_WR;
                end
            end
            S_LD_WR: begin
                o_cmd   = bfsssp_pkg::CMD_LD_WR;
                n_state = S_IDLE;
            end
            S_Q_RD: begin
                o_cmd   = bfsssp_pkg::CMD_Q_RD;
                n_state = S_RESP;
            end
            S_INIT: begin
                o_cmd = bfsssp_pkg::CMD_INIT;
                if (i_status.sweep_last) n_state = S_SRC;
            end
            S_SRC: begin
                o_cmd   = bfsssp_pkg::CMD_SRC;
                n_state = S_ROUND;
            end
            S_ROUND: begin
                if (i_status.round_go) begin
                    o_cmd   = bfsssp_pkg::CMD_RSTART;
                    n_state = S_V_RD;
                end else begin
                    n_state = S_RESP;
                end
            end
            S_V_RD: begin
                if (i_status.vdone) begin
                    n_state = S_ROUND;
                end else begin
                    o_cmd   = bfsssp_pkg::CMD_V_RD;
                    n_state = S_V_CHK;
                end
            end
            S_V_CHK: begin
                priority if (!i_status.v_act) begin
                    o_cmd   = bfsssp_pkg::CMD_V_NEXT;
                    n_state = S_V_RD;
                end else if (i_status.v_inf) begin
                    o_cmd   = bfsssp_pkg::CMD_V_SKIP;
                    n_state = S_V_RD;
                end else begin
                    o_cmd   = bfsssp_pkg::CMD_V_TAKE;
                    n_state = S_E_RD;
                end
            end
            S_E_RD: begin
                if (i_status.e_done) begin
                    o_cmd   = bfsssp_pkg::CMD_V_NEXT;
                    n_state = S_V_RD;
                end else begin
                    o_cmd   = bfsssp_pkg::CMD_E_RD;
                    n_state = S_E_TO;
                end
            end
            S_E_TO: begin
                if (i_status.e_stale) begin
                    o_cmd   = bfsssp_pkg::CMD_E_NEXT;
                    n_state = S_E_RD;
                end else begin
                    o_cmd   = bfsssp_pkg::CMD_E_TO;
                    n_state = S_E_UPD;
                end
            end
            S_E_UPD: begin
                o_cmd   = bfsssp_pkg::CMD_E_UPD;
                n_state = S_E_RD;
            end
            S_RESP: begin
                if (i_status.out_free) begin
                    o_cmd   = bfsssp_pkg::CMD_EMIT;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLR;
        end else begin
            r_state <= n_state;
        end
    end
endmodule
`default_nettype wire

FILE: src/bfsssp_dpath.sv
`default_nettype none
module bfsssp_dpath (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire bfsssp_pkg::t_cmd     i_cmd,
    output bfsssp_pkg::t_status       o_status,
    input  wire logic [1:0]           i_opcode,
    input  wire logic [55:0]          i_in_data,
    input  wire logic                 i_cfg_valid,
    input  wire logic [10:0]          i_cfg_data,
    output logic                      o_out_valid,
    input  wire logic                 i_out_ready,
    output logic [1:0]                o_kind,
    output logic [95:0]               o_out_data
);
    localparam int DB = bfsssp_pkg::DIST_BITS;
    localparam int VB = bfsssp_pkg::V_BITS;
    localparam int NB = bfsssp_pkg::N_BITS;
    localparam int SB = bfsssp_pkg::SLOT_BITS;
    localparam int EB = bfsssp_pkg::E_BITS;
    localparam int PB = bfsssp_pkg::PRED_BITS;
    localparam int WB = bfsssp_pkg::W_BITS;

    logic [NB-1:0]        r_vcount;
    logic [1:0]           r_op;
    logic [VB-1:0]        r_v;
    logic [VB-1:0]        r_dv;
    logic [WB-1:0]        r_w;
    logic [SB-1:0]        r_edges;
    logic [VB-1:0]        r_last;
    logic [NB-1:0]        r_idx;
    logic [SB-1:0]        r_eidx;
    logic [SB-1:0]        r_ecnt;
    logic signed [DB-1:0] r_du;
    logic signed [DB-1:0] r_sum;
    logic [bfsssp_pkg::ROUND_BITS-1:0] r_rounds;
    logic [bfsssp_pkg::TRAV_BITS-1:0]  r_trav;
    logic                 r_any;
    logic                 r_out_valid;
    logic [1:0]           r_kind;
    logic [95:0]          r_out_data;

    logic [NB-1:0]        n_eff;
    logic signed [DB-1:0] dist_rd;
    logic [PB-1:0]        pred_rd;
    logic                 act_rd;
    logic [SB-1:0]        first_rd;
    logic [SB-1:0]        cnt_rd;
    logic [VB-1:0]        edst_rd;
    logic [WB-1:0]        ewt_rd;
    logic signed [DB:0]   sum_raw;
    logic signed [DB-1:0] sum_clamp;
    logic                 improve;
    logic                 q_oob;

    logic dist_we, dist_re, pred_we, pred_re, act_we, act_re, act_wd;
    logic first_we, first_re, cnt_we, cnt_re, e_we, e_re;
    logic [VB-1:0] dist_wa, dist_ra, act_wa, cnt_wa, cnt_ra;
    logic signed [DB-1:0] dist_wd;
    logic [PB-1:0] pred_wd;
    logic [SB-1:0] cnt_wd;

    always_comb begin
        priority if (r_vcount > bfsssp_pkg::N_MAX) n_eff = bfsssp_pkg::N_MAX;
        else if (r_vcount == '0)                   n_eff = NB'(1);
        else                                       n_eff = r_vcount;
    end

    // clamped relaxation sum, kept below infinity
    always_comb begin
        sum_raw = {r_du[DB-1], r_du} + (DB+1)'($signed(ewt_rd));
        priority if (sum_raw > bfsssp_pkg::SUM_HI) sum_clamp = DB'(bfsssp_pkg::SUM_HI);
        else if (sum_raw < bfsssp_pkg::SUM_LO)     sum_clamp = DB'(bfsssp_pkg::SUM_LO);
        else                                       sum_clamp = sum_raw[DB-1:0];
    end

    assign improve = dist_rd > r_sum;
    assign q_oob   = {1'b0, r_v} >= n_eff;

    always_comb begin
        o_status.op         = r_op;
        o_status.out_free   = !r_out_valid || i_out_ready;
        o_status.ld_reject  = ({1'b0, r_v} >= n_eff) || ({1'b0, r_dv} >= n_eff)
                              || (r_edges >= bfsssp_pkg::E_LIMIT) || (r_v < r_last);
        o_status.sweep_last = (r_idx[VB-1:0] == {VB{1'b1}});
        o_status.round_go   = r_any && (({1'b0, r_rounds} + NB'(1)) < n_eff);
        o_status.vdone      = r_idx >= n_eff;
        o_status.v_act      = act_rd;
        o_status.v_inf      = dist_rd == bfsssp_pkg::DIST_INF;
        o_status.e_done     = (r_ecnt == '0) || (r_eidx >= bfsssp_pkg::E_LIMIT);
        o_status.e_stale    = {1'b0, edst_rd} >= n_eff;
    end

    // memory port steering
    always_comb begin
        dist_we = 1'b0; dist_re = 1'b0; dist_wa = r_idx[VB-1:0]; dist_ra = r_idx[VB-1:0];
        dist_wd = bfsssp_pkg::DIST_INF;
        pred_we = 1'b0; pred_re = 1'b0; pred_wd = {PB{1'b1}};
        act_we  = 1'b0; act_re  = 1'b0; act_wa = r_idx[VB-1:0]; act_wd = 1'b1;
        first_we = 1'b0; first_re = 1'b0;
        cnt_we  = 1'b0; cnt_re  = 1'b0; cnt_wa = r_idx[VB-1:0]; cnt_ra = r_idx[VB-1:0];
        cnt_wd  = '0;
        e_we    = 1'b0; e_re    = 1'b0;
        unique case (i_cmd)
            bfsssp_pkg::CMD_CLR: begin
                cnt_we = 1'b1;
            end
            bfsssp_pkg::CMD_LD_RD: begin
                cnt_re = 1'b1; cnt_ra = r_v;
            end
            bfsssp_pkg::CMD_LD_WR: begin
                cnt_we   = 1'b1; cnt_wa = r_v; cnt_wd = cnt_rd + SB'(1);
                first_we = (cnt_rd == '0);
                e_we     = 1'b1;
            end
            bfsssp_pkg::CMD_Q_RD: begin
                dist_re = 1'b1; dist_ra = r_v; pred_re = 1'b1;
            end
            bfsssp_pkg::CMD_INIT: begin
                dist_we = 1'b1; pred_we = 1'b1; act_we = 1'b1;
            end
            bfsssp_pkg::CMD_SRC: begin
                dist_we = !q_oob; dist_wa = r_v; dist_wd = '0;
            end
            bfsssp_pkg::CMD_V_RD: begin
                dist_re = 1'b1; act_re = 1'b1; first_re = 1'b1; cnt_re = 1'b1;
            end
            bfsssp_pkg::CMD_V_SKIP, bfsssp_pkg::CMD_V_TAKE: begin
                act_we = 1'b1; act_wd = 1'b0;
            end
            bfsssp_pkg::CMD_E_RD: begin
                e_re = 1'b1;
            end
            bfsssp_pkg::CMD_E_TO: begin
                dist_re = 1'b1; dist_ra = edst_rd;
            end
            bfsssp_pkg::CMD_E_UPD: begin
                dist_we = improve; dist_wa = edst_rd; dist_wd = r_sum;
                pred_we = improve; pred_wd = {1'b0, r_idx[VB-1:0]};
                act_we  = improve; act_wa = edst_rd;
            end
            default: begin
            end
        endcase
    end

    bfsssp_ram #(.WIDTH(DB), .DEPTH(bfsssp_pkg::MAX_V)) u_dist (
        .i_clk(i_clk), .i_we(dist_we), .i_waddr(dist_wa), .i_wdata(dist_wd),
        .i_re(dist_re), .i_raddr(dist_ra), .o_rdata(dist_rd));

    bfsssp_ram #(.WIDTH(PB), .DEPTH(bfsssp_pkg::MAX_V)) u_pred (
        .i_clk(i_clk), .i_we(pred_we), .i_waddr(dist_wa), .i_wdata(pred_wd),
        .i_re(pred_re), .i_raddr(dist_ra), .o_rdata(pred_rd));

    bfsssp_ram #(.WIDTH(1), .DEPTH(bfsssp_pkg::MAX_V)) u_act (
        .i_clk(i_clk), .i_we(act_we), .i_waddr(act_wa), .i_wdata(act_wd),
        .i_re(act_re), .i_raddr(r_idx[VB-1:0]), .o_rdata(act_rd));

    bfsssp_ram #(.WIDTH(SB), .DEPTH(bfsssp_pkg::MAX_V)) u_first (
        .i_clk(i_clk), .i_we(first_we), .i_waddr(r_v), .i_wdata(r_edges),
        .i_re(first_re), .i_raddr(r_idx[VB-1:0]), .o_rdata(first_rd));

    bfsssp_ram #(.WIDTH(SB), .DEPTH(bfsssp_pkg::MAX_V)) u_cnt (
        .i_clk(i_clk), .i_we(cnt_we), .i_waddr(cnt_wa), .i_wdata(cnt_wd),
        .i_re(cnt_re), .i_raddr(cnt_ra), .o_rdata(cnt_rd));

    bfsssp_ram #(.WIDTH(VB), .DEPTH(bfsssp_pkg::MAX_E)) u_edst (
        .i_clk(i_clk), .i_we(e_we), .i_waddr(r_edges[EB-1:0]), .i_wdata(r_dv),
        .i_re(e_re), .i_raddr(r_eidx[EB-1:0]), .o_rdata(edst_rd));

    bfsssp_ram #(.WIDTH(WB), .DEPTH(bfsssp_pkg::MAX_E)) u_ewt (
        .i_clk(i_clk), .i_we(e_we), .i_waddr(r_edges[EB-1:0]), .i_wdata(r_w),
        .i_re(e_re), .i_raddr(r_eidx[EB-1:0]), .o_rdata(ewt_rd));

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vcount    <= bfsssp_pkg::N_MAX;
            r_edges     <= '0;
            r_last      <= '0;
            r_idx       <= '0;
            r_any       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_valid) r_vcount <= i_cfg_data;
            if (i_cmd == bfsssp_pkg::CMD_EMIT) r_out_valid <= 1'b1;
            else if (r_out_valid && i_out_ready) r_out_valid <= 1'b0;
            unique case (i_cmd)
                bfsssp_pkg::CMD_CAPTURE: r_idx <= '0;
                bfsssp_pkg::CMD_CLR: begin
                    r_idx   <= r_idx + NB'(1);
                    r_edges <= '0;
                    r_last  <= '0;
                end
                bfsssp_pkg::CMD_LD_WR: begin
                    r_edges <= r_edges + SB'(1);
                    r_last  <= r_v;
                end
                bfsssp_pkg::CMD_INIT: begin
                    r_idx <= r_idx + NB'(1);
                    r_any <= 1'b1;
                end
                bfsssp_pkg::CMD_RSTART: begin
                    r_idx <= '0;
                    r_any <= 1'b0;
                end
                bfsssp_pkg::CMD_V_NEXT, bfsssp_pkg::CMD_V_SKIP: r_idx <= r_idx + NB'(1);
                bfsssp_pkg::CMD_E_UPD: if (improve) r_any <= 1'b1;
                default: begin
                end
            endcase
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        unique case (i_cmd)
            bfsssp_pkg::CMD_CAPTURE: begin
                r_op <= i_opcode;
                r_v  <= i_in_data[9:0];
                r_dv <= i_in_data[19:10];
                r_w  <= i_in_data[51:20];
            end
            bfsssp_pkg::CMD_INIT: begin
                r_rounds <= '0;
                r_trav   <= '0;
            end
            bfsssp_pkg::CMD_RSTART: r_rounds <= r_rounds + 1'b1;
            bfsssp_pkg::CMD_V_TAKE: begin
                r_du   <= dist_rd;
                r_eidx <= first_rd;
                r_ecnt <= cnt_rd;
            end
            bfsssp_pkg::CMD_E_NEXT: begin
                r_eidx <= r_eidx + SB'(1);
                r_ecnt <= r_ecnt - SB'(1);
            end
            bfsssp_pkg::CMD_E_TO: r_sum <= sum_clamp;
            bfsssp_pkg::CMD_E_UPD: begin
                // a self loop that improves feeds the rest of this vertex's edges
                if (improve && (edst_rd == r_idx[VB-1:0])) r_du <= r_sum;
                if (r_trav < bfsssp_pkg::TRAV_CAP) r_trav <= r_trav + 1'b1;
                r_eidx <= r_eidx + SB'(1);
                r_ecnt <= r_ecnt - SB'(1);
            end
            bfsssp_pkg::CMD_EMIT: begin
                unique case (r_op)
                    bfsssp_pkg::OP_RUN: begin
                        r_kind     <= bfsssp_pkg::KIND_RUN;
                        r_out_data <= {3'b0, r_trav, r_rounds, 60'b0};
                    end
                    bfsssp_pkg::OP_QUERY: begin
                        r_kind <= bfsssp_pkg::KIND_QUERY;
                        if (q_oob) begin
                            r_out_data <= {37'b0, {PB{1'b1}}, bfsssp_pkg::DIST_INF};
                        end else begin
                            r_out_data <= {36'b0, (dist_rd != bfsssp_pkg::DIST_INF),
                                           pred_rd, dist_rd};
                        end
                    end
                    default: begin
                        r_kind     <= bfsssp_pkg::KIND_REJECT;
                        r_out_data <= '0;
                    end
                endcase
            end
            default: begin
            end
        endcase
    end

    assign o_out_valid = r_out_valid;
    assign o_kind      = r_kind;
    assign o_out_data  = r_out_data;
endmodule
`default_nettype wire

FILE: src/bellman_ford_sssp_engine_top.sv
`default_nettype none
// channel   | direction | handshake                    | payload
// s_axis    | in        | s_axis_tvalid/s_axis_tready  | tuser opcode; tdata edge or vertex
// m_axis    | out       | m_axis_tvalid/m_axis_tready  | tuser kind; tdata result fields
// cfg       | in        | i_cfg_valid/o_cfg_ready      | i_cfg_data vertex_count
//
// one item at a time; clear sweeps every edge count
// a run first initialises the distance, predecessor and active tables, then each round
// visits every vertex and relaxes the edges of each finite active one, skipping stale edges
// each relaxed edge reads the distance memory before it writes it back
// after reset a sweep clears the edge counts before input is taken
// a held result lets the next item in, which then waits until the held result leaves
module bellman_ford_sssp_engine_top (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [55:0] s_axis_tdata,  // vertex, dest_vertex, edge_weight, zero pad
    input  wire logic [1:0]  s_axis_tuser,  // opcode
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [95:0]      m_axis_tdata,  // distance, predecessor, reachable,
                                            // rounds_used, traversed_edges, zero pad
    output logic [1:0]       m_axis_tuser,  // kind
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [10:0] i_cfg_data
);
    bfsssp_pkg::t_cmd    cmd;
    bfsssp_pkg::t_status status;

    assign o_cfg_ready = 1'b1;

    bfsssp_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    bfsssp_dpath u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_status    (status),
        .i_opcode    (s_axis_tuser),
        .i_in_data   (s_axis_tdata),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_data  (i_cfg_data),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .o_kind      (m_axis_tuser),
        .o_out_data  (m_axis_tdata)
    );
endmodule
`default_nettype wire
